/* src/sm83_pkg.sv */
`timescale 1ns / 1ps

package sm83_pkg;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADC   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SBC   = 5'd3,
		OP_AND   = 5'd4,
		OP_XOR   = 5'd5,
		OP_OR    = 5'd6,
		OP_CP    = 5'd7,
		OP_RLC   = 5'd8,
		OP_RRC   = 5'd9,
		OP_RL    = 5'd10,
		OP_RR    = 5'd11,
		OP_SLA   = 5'd12,
		OP_SRA   = 5'd13,
		OP_SWAP  = 5'd14,
		OP_SRL   = 5'd15,
		OP_RLCA  = 5'd16,
		OP_RRCA  = 5'd17,
		OP_RLA   = 5'd18,
		OP_RRA   = 5'd19,
		OP_DAA   = 5'd20,
		OP_CPL   = 5'd21,
		OP_SCF   = 5'd22,
		OP_CCF   = 5'd23,
		OP_BIT   = 5'd24,
		OP_RES   = 5'd25,
		OP_SET   = 5'd26,
		OP_INC   = 5'd27,
		OP_DEC   = 5'd28,
		OP_ADD16 = 5'd29,
		OP_ADDSP = 5'd30
	} op_t;

	// Bit positions inside the four-bit flag nibble.
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	localparam logic [7:0] DAA_LIMIT    = 8'h99;
	localparam logic [7:0] DAA_HI_CORR  = 8'h60;
	localparam logic [7:0] DAA_LO_CORR  = 8'h06;
	localparam logic [3:0] BCD_MAX      = 4'd9;

	typedef struct packed {
		logic [4:0]  req_type;
		logic [15:0] first_operand;
		logic [15:0] second_operand;
		logic [2:0]  bit_index;
		logic [3:0]  flags_in;
	} req_t;

	typedef struct packed {
		logic [15:0] result_value;
		logic [3:0]  flags_out;
		logic        writes_result;
	} rsp_t;

endpackage

/* src/sm83_req_if.sv */
`timescale 1ns / 1ps

interface sm83_req_if;
	logic        valid;
	logic        ready;
	logic [4:0]  req_type;
	logic [15:0] first_operand;
	logic [15:0] second_operand;
	logic [2:0]  bit_index;
	logic [3:0]  flags_in;

	modport source (
		output valid, req_type, first_operand, second_operand, bit_index, flags_in,
		input  ready
	);
	modport sink (
		input  valid, req_type, first_operand, second_operand, bit_index, flags_in,
		output ready
	);
endinterface

/* src/sm83_rsp_if.sv */
`timescale 1ns / 1ps

interface sm83_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_value;
	logic [3:0]  flags_out;
	logic        writes_result;

	modport source (
		output valid, result_value, flags_out, writes_result,
		input  ready
	);
	modport sink (
		input  valid, result_value, flags_out, writes_result,
		output ready
	);
endinterface

/* src/sm83_alu_core.sv */
`timescale 1ns / 1ps

module sm83_alu_core (
	input  sm83_pkg::req_t req,
	output sm83_pkg::rsp_t rsp
);

	logic [7:0]  a;
	logic [7:0]  b;
	logic [15:0] w1;
	logic [15:0] w2;
	logic [3:0]  fin;
	logic        cy;
	logic [8:0]  sum9;
	logic [4:0]  hsum;
	logic [8:0]  diff9;
	logic [4:0]  hdiff;
	logic [7:0]  sh_r;
	logic        sh_out;
	logic        daa_c;
	logic [7:0]  daa_corr;
	logic [7:0]  daa_r;
	logic [7:0]  mask;
	logic [7:0]  inc_r;
	logic [7:0]  dec_r;
	logic [16:0] add16;
	logic [12:0] add12;
	logic [15:0] ext;
	logic [8:0]  sp_lo;
	logic [4:0]  sp_nib;

	assign a    = req.first_operand[7:0];
	assign b    = req.second_operand[7:0];
	assign w1   = req.first_operand;
	assign w2   = req.second_operand;
	assign fin  = req.flags_in;
	assign mask = 8'(1) << req.bit_index;

	assign cy = ((sm83_pkg::op_t'(req.req_type) == sm83_pkg::OP_ADC) ||
	             (sm83_pkg::op_t'(req.req_type) == sm83_pkg::OP_SBC)) && fin[sm83_pkg::FLAG_C];

	assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cy};
	assign hsum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy};
	// Bit 8 of the difference is the borrow, i.e. a < b + carry.
	assign diff9 = {1'b0, a} - {1'b0, b} - {8'd0, cy};
	assign hdiff = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cy};

	assign inc_r  = a + 8'd1;
	assign dec_r  = a - 8'd1;
	assign add16  = {1'b0, w1} + {1'b0, w2};
	assign add12  = {1'b0, w1[11:0]} + {1'b0, w2[11:0]};
	assign ext    = {{8{b[7]}}, b};
	assign sp_lo  = {1'b0, w1[7:0]} + {1'b0, b};
	assign sp_nib = {1'b0, w1[3:0]} + {1'b0, b[3:0]};

	always_comb begin
		sh_r   = a;
		sh_out = 1'b0;
		case (sm83_pkg::op_t'(req.req_type))
			sm83_pkg::OP_RLC, sm83_pkg::OP_RLCA: begin
				sh_out = a[7];
				sh_r   = {a[6:0], a[7]};
			end
			sm83_pkg::OP_RRC, sm83_pkg::OP_RRCA: begin
				sh_out = a[0];
				sh_r   = {a[0], a[7:1]};
			end
			sm83_pkg::OP_RL, sm83_pkg::OP_RLA: begin
				sh_out = a[7];
				sh_r   = {a[6:0], fin[sm83_pkg::FLAG_C]};
			end
			sm83_pkg::OP_RR, sm83_pkg::OP_RRA: begin
				sh_out = a[0];
				sh_r   = {fin[sm83_pkg::FLAG_C], a[7:1]};
			end
			sm83_pkg::OP_SLA: begin
				sh_out = a[7];
				sh_r   = {a[6:0], 1'b0};
			end
			sm83_pkg::OP_SRA: begin
				sh_out = a[0];
				sh_r   = {a[7], a[7:1]};
			end
			sm83_pkg::OP_SWAP: begin
				sh_r = {a[3:0], a[7:4]};
			end
			sm83_pkg::OP_SRL: begin
				sh_out = a[0];
				sh_r   = {1'b0, a[7:1]};
			end
			default: begin
				sh_r   = a;
				sh_out = 1'b0;
			end
		endcase
	end

	always_comb begin
		daa_corr = 8'd0;
		daa_c    = fin[sm83_pkg::FLAG_C];
		if (!fin[sm83_pkg::FLAG_N]) begin
			if (fin[sm83_pkg::FLAG_C] || (a > sm83_pkg::DAA_LIMIT)) begin
				daa_corr = daa_corr | sm83_pkg::DAA_HI_CORR;
				daa_c    = 1'b1;
			end
			if (fin[sm83_pkg::FLAG_H] || (a[3:0] > sm83_pkg::BCD_MAX)) begin
				daa_corr = daa_corr | sm83_pkg::DAA_LO_CORR;
			end
			daa_r = a + daa_corr;
		end else begin
			if (fin[sm83_pkg::FLAG_C]) begin
				daa_corr = daa_corr | sm83_pkg::DAA_HI_CORR;
			end
			if (fin[sm83_pkg::FLAG_H]) begin
				daa_corr = daa_corr | sm83_pkg::DAA_LO_CORR;
			end
			daa_r = a - daa_corr;
		end
	end

	always_comb begin
		rsp.result_value  = {8'd0, a};
		rsp.flags_out     = fin;
		rsp.writes_result = 1'b1;
		case (sm83_pkg::op_t'(req.req_type))
			sm83_pkg::OP_ADD, sm83_pkg::OP_ADC: begin
				rsp.result_value = {8'd0, sum9[7:0]};
				rsp.flags_out    = {sum9[7:0] == 8'd0, 1'b0, hsum[4], sum9[8]};
			end
			sm83_pkg::OP_SUB, sm83_pkg::OP_SBC: begin
				rsp.result_value = {8'd0, diff9[7:0]};
				rsp.flags_out    = {diff9[7:0] == 8'd0, 1'b1, hdiff[4], diff9[8]};
			end
			sm83_pkg::OP_CP: begin
				rsp.flags_out     = {diff9[7:0] == 8'd0, 1'b1, hdiff[4], diff9[8]};
				rsp.writes_result = 1'b0;
			end
			sm83_pkg::OP_AND: begin
				rsp.result_value = {8'd0, a & b};
				rsp.flags_out    = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
			end
			sm83_pkg::OP_XOR: begin
				rsp.result_value = {8'd0, a ^ b};
				rsp.flags_out    = {(a ^ b) == 8'd0, 3'b000};
			end
			sm83_pkg::OP_OR: begin
				rsp.result_value = {8'd0, a | b};
				rsp.flags_out    = {(a | b) == 8'd0, 3'b000};
			end
			sm83_pkg::OP_RLC, sm83_pkg::OP_RRC, sm83_pkg::OP_RL, sm83_pkg::OP_RR,
			sm83_pkg::OP_SLA, sm83_pkg::OP_SRA, sm83_pkg::OP_SWAP, sm83_pkg::OP_SRL: begin
				rsp.result_value = {8'd0, sh_r};
				rsp.flags_out    = {sh_r == 8'd0, 2'b00, sh_out};
			end
			// The accumulator rotates always clear Z.
			sm83_pkg::OP_RLCA, sm83_pkg::OP_RRCA, sm83_pkg::OP_RLA, sm83_pkg::OP_RRA: begin
				rsp.result_value = {8'd0, sh_r};
				rsp.flags_out    = {3'b000, sh_out};
			end
			sm83_pkg::OP_DAA: begin
				rsp.result_value = {8'd0, daa_r};
				rsp.flags_out    = {daa_r == 8'd0, fin[sm83_pkg::FLAG_N], 1'b0, daa_c};
			end
			sm83_pkg::OP_CPL: begin
				rsp.result_value = {8'd0, ~a};
				rsp.flags_out    = {fin[sm83_pkg::FLAG_Z], 2'b11, fin[sm83_pkg::FLAG_C]};
			end
			sm83_pkg::OP_SCF: begin
				rsp.flags_out     = {fin[sm83_pkg::FLAG_Z], 3'b001};
				rsp.writes_result = 1'b0;
			end
			sm83_pkg::OP_CCF: begin
				rsp.flags_out     = {fin[sm83_pkg::FLAG_Z], 2'b00, ~fin[sm83_pkg::FLAG_C]};
				rsp.writes_result = 1'b0;
			end
			sm83_pkg::OP_BIT: begin
				rsp.flags_out     = {(a & mask) == 8'd0, 2'b01, fin[sm83_pkg::FLAG_C]};
				rsp.writes_result = 1'b0;
			end
			sm83_pkg::OP_RES: begin
				rsp.result_value = {8'd0, a & ~mask};
			end
			sm83_pkg::OP_SET: begin
				rsp.result_value = {8'd0, a | mask};
			end
			sm83_pkg::OP_INC: begin
				rsp.result_value = {8'd0, inc_r};
				rsp.flags_out    = {inc_r == 8'd0, 1'b0, a[3:0] == 4'hF,
				                    fin[sm83_pkg::FLAG_C]};
			end
			sm83_pkg::OP_DEC: begin
				rsp.result_value = {8'd0, dec_r};
				rsp.flags_out    = {dec_r == 8'd0, 1'b1, a[3:0] == 4'h0,
				                    fin[sm83_pkg::FLAG_C]};
			end
			sm83_pkg::OP_ADD16: begin
				rsp.result_value = add16[15:0];
				rsp.flags_out    = {fin[sm83_pkg::FLAG_Z], 1'b0, add12[12], add16[16]};
			end
			// ADD SP,e takes H and C from the low byte, unsigned.
			sm83_pkg::OP_ADDSP: begin
				rsp.result_value = w1 + ext;
				rsp.flags_out    = {2'b00, sp_nib[4], sp_lo[8]};
			end
			default: begin
				rsp.result_value  = w1;
				rsp.flags_out     = fin;
				rsp.writes_result = 1'b0;
			end
		endcase
	end

endmodule

/* src/sm83_alu_flags_unit.sv */
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Payload
// req      in   valid / ready  req_type, first_operand, second_operand, bit_index, flags_in
// rsp      out  valid / ready  result_value, flags_out, writes_result
//
// An accepted request passes through the input register, then the ALU and flag logic,
// then the result register. One transaction per cycle is sustained while rsp.ready is high.
// Reset clears both stage valid bits; the pipeline is empty afterwards.
// A stalled response holds the result register; the input stage still takes one more
// request, and only when both stages are full does req.ready drop.

module sm83_alu_flags_unit (
	input logic       clk,
	input logic       arst_n,
	sm83_req_if.sink  req,
	sm83_rsp_if.source rsp
);

	logic           valid_s1;
	logic           valid_s2;
	sm83_pkg::req_t req_s1;
	sm83_pkg::rsp_t rsp_s2;
	sm83_pkg::rsp_t core_rsp;
	logic           adv_s1;
	logic           adv_s2;

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			req_s1.req_type       <= req.req_type;
			req_s1.first_operand  <= req.first_operand;
			req_s1.second_operand <= req.second_operand;
			req_s1.bit_index      <= req.bit_index;
			req_s1.flags_in       <= req.flags_in;
		end
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= core_rsp;
		end
	end

	sm83_alu_core u_core (
		.req (req_s1),
		.rsp (core_rsp)
	);

	assign rsp.valid         = valid_s2;
	assign rsp.result_value  = rsp_s2.result_value;
	assign rsp.flags_out     = rsp_s2.flags_out;
	assign rsp.writes_result = rsp_s2.writes_result;

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !valid_s1 && !valid_s2)
		else $error("pipeline not empty during reset");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !rsp.ready) |-> !req.ready)
		else $error("request taken while both stages are full");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(req_s1)))
		else $error("input stage lost its transaction during a stall");

	a_s2_load: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> (valid_s2 && rsp_s2 == $past(core_rsp)))
		else $error("result register did not capture the ALU output");

endmodule
